>>> rtl/range_flow_table_switch_assert.svh
// assertion macros shared by the checker of the flow-table switch
// no dependencies; take in by include after the package is compiled
`ifndef RANGE_FLOW_TABLE_SWITCH_ASSERT_SVH
`define RANGE_FLOW_TABLE_SWITCH_ASSERT_SVH

// same-cycle implication
`define RFTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rfts check failed");

// next-cycle implication
`define RFTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rfts check failed");

`endif

>>> rtl/rfts_pkg.sv
// shared types, codes and helpers of the flow-table switch
// no dependencies
package rfts_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int IDX_W       = 8;
	localparam int COUNT_W     = 16;
	localparam int ADDR_W      = 10;
	localparam int CFG_IDX_W   = 2;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [2:0] {
		ACT_TRAFFIC  = 3'd0,
		ACT_ADD_FWD  = 3'd1,
		ACT_ADD_DROP = 3'd2,
		ACT_RELAY    = 3'd3,
		ACT_ACK      = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		DEC_NONE  = 3'd0,
		DEC_HOLD  = 3'd1,
		DEC_ADMIT = 3'd2,
		DEC_RELAY = 3'd3,
		DEC_QUERY = 3'd4,
		DEC_DROP  = 3'd5,
		DEC_FULL  = 3'd6
	} decision_t;

	typedef enum logic [1:0] {
		MODE_DISC = 2'd0,
		MODE_CONN = 2'd1,
		MODE_WAIT = 2'd2
	} mode_t;

	localparam logic [1:0] PORT_NONE  = 2'd0;
	localparam logic [1:0] PORT_LEFT  = 2'd1;
	localparam logic [1:0] PORT_RIGHT = 2'd2;
	localparam logic [1:0] PORT_LOCAL = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_ID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_LOW   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_HIGH  = 2'd2;

	// what the back end does with a command
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_LOCAL = 2'd1,
		OP_HIT   = 2'd2,
		OP_SET   = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		decision_t        decision;
		logic [1:0]       port;
		logic [IDX_W-1:0] idx;
		logic             is_drop;
		mode_t            mode;
	} cmd_t;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
		return (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
	endfunction

endpackage

>>> rtl/rfts_ifs.sv
// valid/ready channel interfaces of the flow-table switch
// depends on rfts_pkg
interface rfts_in_if;
	logic                               valid;
	logic                               ready;
	logic [2:0]                         action;
	logic [2:0]                         target_switch;
	logic [rfts_pkg::ADDR_W-1:0]        dest_ip;
	logic [rfts_pkg::ADDR_W-1:0]        range_low;
	logic [rfts_pkg::ADDR_W-1:0]        range_high;
	modport source(output valid, action, target_switch, dest_ip, range_low, range_high,
		input ready);
	modport sink(input valid, action, target_switch, dest_ip, range_low, range_high,
		output ready);
endinterface

interface rfts_out_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    decision;
	logic [1:0]                    port;
	logic [3:0]                    entry_index;
	logic [rfts_pkg::COUNT_W-1:0]  entry_count;
	logic [1:0]                    mode;
	modport source(output valid, decision, port, entry_index, entry_count, mode,
		input ready);
	modport sink(input valid, decision, port, entry_index, entry_count, mode,
		output ready);
endinterface

>>> rtl/rfts_front.sv
// front end: takes items, range lookup, mode and rule allocation, issues commands
// depends on rfts_pkg and rfts_in_if
module rfts_front #(
	parameter int ENTRIES = rfts_pkg::ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	rfts_in_if.sink                     item,
	input  logic [2:0]                  switch_id,
	input  logic [rfts_pkg::ADDR_W-1:0] own_low,
	input  logic [rfts_pkg::ADDR_W-1:0] own_high,
	output rfts_pkg::cmd_t              cmd,
	output logic                        cmd_valid,
	input  logic                        cmd_ready
);
	localparam int IW = $clog2(ENTRIES);
	localparam int UW = $clog2(ENTRIES + 1);

	logic                        busy_q;
	rfts_pkg::mode_t             mode_q;
	logic [UW-1:0]               used_q;
	logic [rfts_pkg::ADDR_W-1:0] rule_lo_q [ENTRIES];
	logic [rfts_pkg::ADDR_W-1:0] rule_hi_q [ENTRIES];

	logic [2:0]                  act_s1;
	logic [2:0]                  tgt_s1;
	logic [rfts_pkg::ADDR_W-1:0] dest_s1;
	logic [rfts_pkg::ADDR_W-1:0] lo_s1;
	logic [rfts_pkg::ADDR_W-1:0] hi_s1;
	logic [ENTRIES-1:0]          hit_s1;

	logic [ENTRIES-1:0]          hit_c;
	logic [ENTRIES-1:0]          hit_low;
	logic [IW-1:0]               hit_idx;
	logic                        own_hit;
	logic                        full;
	logic                        add_en;
	logic                        fire;
	rfts_pkg::mode_t             mode_d;
	rfts_pkg::cmd_t              cmd_c;

	assign item.ready = !busy_q;
	assign cmd_valid  = busy_q;
	assign cmd        = cmd_c;
	assign fire       = busy_q && cmd_ready;

	// compare the arriving address against every learned rule lane
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			hit_c[i] = (i != 0) && (UW'(i) < used_q) &&
				(rule_lo_q[i] <= item.dest_ip) && (item.dest_ip <= rule_hi_q[i]);
		end
	end

	// first match: isolate lowest set bit, then encode
	always_comb begin
		hit_low = hit_s1 & (~hit_s1 + 1'b1);
		hit_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_idx = hit_idx | (hit_low[i] ? IW'(i) : '0);
		end
	end

	assign own_hit = (own_low <= dest_s1) && (dest_s1 <= own_high);
	assign full    = used_q >= UW'(ENTRIES);

	// classify the held item
	always_comb begin
		cmd_c          = '0;
		cmd_c.op       = rfts_pkg::OP_NONE;
		cmd_c.decision = rfts_pkg::DEC_NONE;
		cmd_c.port     = rfts_pkg::PORT_NONE;
		mode_d         = mode_q;
		add_en         = 1'b0;
		unique case (act_s1)
			rfts_pkg::ACT_TRAFFIC: begin
				priority if (mode_q != rfts_pkg::MODE_CONN) begin
					cmd_c.decision = rfts_pkg::DEC_HOLD;
				end else if (tgt_s1 != switch_id) begin
					cmd_c.decision = rfts_pkg::DEC_NONE;
				end else if (own_hit) begin
					cmd_c.op = rfts_pkg::OP_LOCAL;
				end else if (|hit_s1) begin
					cmd_c.op  = rfts_pkg::OP_HIT;
					cmd_c.idx = rfts_pkg::IDX_W'(hit_idx);
				end else begin
					mode_d         = rfts_pkg::MODE_WAIT;
					cmd_c.decision = rfts_pkg::DEC_QUERY;
				end
			end
			rfts_pkg::ACT_ADD_FWD, rfts_pkg::ACT_ADD_DROP: begin
				mode_d = rfts_pkg::MODE_CONN;
				if (full) begin
					cmd_c.decision = rfts_pkg::DEC_FULL;
				end else begin
					add_en        = 1'b1;
					cmd_c.op      = rfts_pkg::OP_SET;
					cmd_c.idx     = rfts_pkg::IDX_W'(used_q);
					cmd_c.is_drop = (act_s1 == rfts_pkg::ACT_ADD_DROP);
					if (act_s1 == rfts_pkg::ACT_ADD_DROP) begin
						cmd_c.port = rfts_pkg::PORT_NONE;
					end else if (tgt_s1 == switch_id) begin
						cmd_c.port = rfts_pkg::PORT_RIGHT;
					end else begin
						cmd_c.port = rfts_pkg::PORT_LEFT;
					end
				end
			end
			rfts_pkg::ACT_RELAY: begin
				cmd_c.op = rfts_pkg::OP_LOCAL;
			end
			rfts_pkg::ACT_ACK: begin
				mode_d = rfts_pkg::MODE_CONN;
			end
			default: begin
				cmd_c.decision = rfts_pkg::DEC_NONE;
			end
		endcase
		cmd_c.mode = mode_d;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mode_q <= rfts_pkg::MODE_DISC;
			used_q <= UW'(1);
		end else begin
			if (item.valid && item.ready) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				mode_q <= mode_d;
				if (add_en) begin
					used_q <= used_q + 1'b1;
				end
			end
		end
	end

	// held item and its match vector
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			act_s1  <= item.action;
			tgt_s1  <= item.target_switch;
			dest_s1 <= item.dest_ip;
			lo_s1   <= item.range_low;
			hi_s1   <= item.range_high;
			hit_s1  <= hit_c;
		end
	end

	// rule range lanes
	always_ff @(posedge clk) begin
		if (fire && add_en) begin
			if (act_s1 == rfts_pkg::ACT_ADD_DROP) begin
				rule_lo_q[used_q[IW-1:0]] <= dest_s1;
				rule_hi_q[used_q[IW-1:0]] <= dest_s1;
			end else begin
				rule_lo_q[used_q[IW-1:0]] <= lo_s1;
				rule_hi_q[used_q[IW-1:0]] <= hi_s1;
			end
		end
	end

endmodule

>>> rtl/rfts_queue.sv
// two-entry command queue between front and back end
// depends on rfts_pkg
module rfts_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  rfts_pkg::cmd_t wr_cmd,
	input  logic           wr_valid,
	output logic           wr_ready,
	output rfts_pkg::cmd_t rd_cmd,
	output logic           rd_valid,
	input  logic           rd_ready
);
	rfts_pkg::cmd_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_cmd   = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

>>> rtl/rfts_back.sv
// back end: count read-modify-write, rule action memory and result register
// depends on rfts_pkg and rfts_out_if
module rfts_back #(
	parameter int ENTRIES = rfts_pkg::ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rfts_pkg::cmd_t cmd,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	rfts_out_if.source     result
);
	localparam int IW = $clog2(ENTRIES);
	localparam int MW = rfts_pkg::COUNT_W + 3;

	// per rule word: drop flag, port, count
	logic [MW-1:0]                rule_mem [ENTRIES];
	logic [MW-1:0]                rd_q;
	logic                         busy_q;
	rfts_pkg::cmd_t               cmd_s1;
	logic [rfts_pkg::COUNT_W-1:0] local_q;

	logic                         out_valid_q;
	logic [2:0]                   dec_q;
	logic [1:0]                   port_q;
	logic [3:0]                   idx_q;
	logic [rfts_pkg::COUNT_W-1:0] cnt_q;
	logic [1:0]                   mode_q;

	logic                         pop;
	logic                         done;
	logic                         wr_en;
	logic [MW-1:0]                wr_data;
	logic [2:0]                   dec_c;
	logic [1:0]                   port_c;
	logic [3:0]                   idx_c;
	logic [rfts_pkg::COUNT_W-1:0] cnt_c;
	logic [rfts_pkg::COUNT_W-1:0] rule_inc;

	assign cmd_ready   = !busy_q;
	assign pop         = cmd_valid && cmd_ready;
	assign done        = busy_q && (!out_valid_q || result.ready);
	assign rule_inc    = rfts_pkg::sat_inc(rd_q[rfts_pkg::COUNT_W-1:0]);

	assign result.valid       = out_valid_q;
	assign result.decision    = dec_q;
	assign result.port        = port_q;
	assign result.entry_index = idx_q;
	assign result.entry_count = cnt_q;
	assign result.mode        = mode_q;

	// carry out the command
	always_comb begin
		dec_c   = cmd_s1.decision;
		port_c  = rfts_pkg::PORT_NONE;
		idx_c   = '0;
		cnt_c   = '0;
		wr_en   = 1'b0;
		wr_data = rd_q;
		unique case (cmd_s1.op)
			rfts_pkg::OP_LOCAL: begin
				dec_c  = rfts_pkg::DEC_ADMIT;
				port_c = rfts_pkg::PORT_LOCAL;
				cnt_c  = rfts_pkg::sat_inc(local_q);
			end
			rfts_pkg::OP_HIT: begin
				wr_en   = 1'b1;
				wr_data = {rd_q[MW-1:rfts_pkg::COUNT_W], rule_inc};
				idx_c   = 4'(cmd_s1.idx);
				cnt_c   = rule_inc;
				if (rd_q[MW-1]) begin
					dec_c = rfts_pkg::DEC_DROP;
				end else begin
					dec_c  = rfts_pkg::DEC_RELAY;
					port_c = rd_q[MW-2:rfts_pkg::COUNT_W];
				end
			end
			rfts_pkg::OP_SET: begin
				wr_en   = 1'b1;
				wr_data = {cmd_s1.is_drop, cmd_s1.port, rfts_pkg::COUNT_W'(1)};
				idx_c   = 4'(cmd_s1.idx);
				cnt_c   = rfts_pkg::COUNT_W'(1);
				port_c  = cmd_s1.port;
				dec_c   = cmd_s1.is_drop ? rfts_pkg::DEC_DROP : rfts_pkg::DEC_RELAY;
			end
			default: begin
				dec_c = cmd_s1.decision;
			end
		endcase
	end

	// control and local count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			local_q     <= '0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (done && cmd_s1.op == rfts_pkg::OP_LOCAL) begin
				local_q <= cnt_c;
			end
		end
	end

	// command and result beat registers
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1 <= cmd;
		end
		if (done) begin
			dec_q  <= dec_c;
			port_q <= port_c;
			idx_q  <= idx_c;
			cnt_q  <= cnt_c;
			mode_q <= cmd_s1.mode;
		end
	end

	// rule memory, one read and one write port
	always_ff @(posedge clk) begin
		if (pop) begin
			rd_q <= rule_mem[cmd.idx[IW-1:0]];
		end
		if (done && wr_en) begin
			rule_mem[cmd_s1.idx[IW-1:0]] <= wr_data;
		end
	end

endmodule

>>> rtl/range_flow_table_switch.sv
// top level of the flow-table switch: configuration registers, front, queue, back
// depends on rfts_pkg, rfts_ifs, rfts_front, rfts_queue, rfts_back
//
// channel  | dir | beat
// item     | in  | action, target_switch, dest_ip, range_low, range_high
// result   | out | decision, port, entry_index, entry_count, mode
// cfg      | in  | cfg_wr_en, cfg_index, cfg_data (write only)
//
// the front compares an item against all rule lanes as it takes it, then classifies
// it and pushes it into the two-entry queue before it takes the next item
// the back does the rule memory read-modify-write before it takes the next command
// a result passes the held item, queue slot, back command and result registers
// reset clears mode and local count and sets rule count to one; rule memory needs
// no clearing pass; each side runs alone while the queue has room or holds commands
module range_flow_table_switch #(
	parameter int ENTRIES = rfts_pkg::ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rfts_in_if.sink                        item,
	rfts_out_if.source                     result,
	input  logic                           cfg_wr_en,
	input  logic [rfts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rfts_pkg::ADDR_W-1:0]    cfg_data
);
	logic [2:0]                  switch_id_q;
	logic [rfts_pkg::ADDR_W-1:0] own_low_q;
	logic [rfts_pkg::ADDR_W-1:0] own_high_q;

	rfts_pkg::cmd_t f_cmd;
	logic           f_valid;
	logic           f_ready;
	rfts_pkg::cmd_t b_cmd;
	logic           b_valid;
	logic           b_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_id_q <= 3'd1;
			own_low_q   <= '0;
			own_high_q  <= rfts_pkg::ADDR_W'(1000);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				rfts_pkg::CFG_SWITCH_ID: switch_id_q <= cfg_data[2:0];
				rfts_pkg::CFG_OWN_LOW:   own_low_q   <= cfg_data;
				rfts_pkg::CFG_OWN_HIGH:  own_high_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rfts_front #(.ENTRIES(ENTRIES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.switch_id (switch_id_q),
		.own_low   (own_low_q),
		.own_high  (own_high_q),
		.cmd       (f_cmd),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready)
	);

	rfts_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cmd   (f_cmd),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.rd_cmd   (b_cmd),
		.rd_valid (b_valid),
		.rd_ready (b_ready)
	);

	rfts_back #(.ENTRIES(ENTRIES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (b_cmd),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.result    (result)
	);

endmodule

>>> rtl/rfts_checker.sv
// port-level checks of the flow-table switch and their bind
// depends on rfts_pkg and range_flow_table_switch_assert.svh
`include "range_flow_table_switch_assert.svh"

module rfts_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] decision,
	input logic [1:0] port,
	input logic [3:0] entry_index,
	input logic [1:0] mode
);
	// a local admit always names the local port and entry zero
	`RFTS_ASSERT_IMP(a_admit_local, clk, arst_n, out_valid && decision == rfts_pkg::DEC_ADMIT, port == rfts_pkg::PORT_LOCAL && entry_index == 4'd0)
	// a controller query leaves the switch waiting, with no port or entry
	`RFTS_ASSERT_IMP(a_query_wait, clk, arst_n, out_valid && decision == rfts_pkg::DEC_QUERY, mode == rfts_pkg::MODE_WAIT && port == rfts_pkg::PORT_NONE && entry_index == 4'd0)
	// a held packet is only reported while not connected
	`RFTS_ASSERT_IMP(a_hold_mode, clk, arst_n, out_valid && decision == rfts_pkg::DEC_HOLD, mode != rfts_pkg::MODE_CONN)
	// the front drops ready once it takes an item
	`RFTS_ASSERT_NXT(a_front_gap, clk, arst_n, in_valid && in_ready, !in_ready)
	// a stalled result beat stays offered
	`RFTS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule

bind range_flow_table_switch rfts_checker u_rfts_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (item.valid),
	.in_ready    (item.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.decision    (result.decision),
	.port        (result.port),
	.entry_index (result.entry_index),
	.mode        (result.mode)
);

>>> tb/sv/range_flow_table_switch_test.sv
// self-checking testbench of the flow-table switch: directed, counting and random traffic
// depends on rfts_pkg, rfts_ifs and range_flow_table_switch
module range_flow_table_switch_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_ENTRIES = rfts_pkg::ENTRIES_DEF;
	localparam int DRAIN_CYCLES = 10;

	typedef struct {
		rfts_pkg::decision_t decision;
		logic [1:0]          port;
		logic [3:0]          entry_index;
		logic [15:0]         entry_count;
		rfts_pkg::mode_t     mode;
	} verdict_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [rfts_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rfts_pkg::ADDR_W-1:0] cfg_data;

	rfts_in_if  item();
	rfts_out_if result();

	range_flow_table_switch dut (
		.clk(clk), .arst_n(arst_n), .item(item), .result(result),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow of the switch state
	logic [2:0]                  my_switch;
	logic [rfts_pkg::ADDR_W-1:0] local_lo, local_hi;
	logic [rfts_pkg::ADDR_W-1:0] tbl_lo[NUM_ENTRIES];
	logic [rfts_pkg::ADDR_W-1:0] tbl_hi[NUM_ENTRIES];
	logic                        tbl_drop[NUM_ENTRIES];
	logic [1:0]                  tbl_port[NUM_ENTRIES];
	logic [15:0]                 tbl_hits[NUM_ENTRIES];
	logic [15:0]                 local_hits;
	int unsigned                 tbl_used;
	rfts_pkg::mode_t             link;

	verdict_t pending_verdicts[$];
	int unsigned errors;
	int unsigned tx_gap_pct, rx_idle_pct, stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	function automatic logic [15:0] bump(input logic [15:0] c);
		return (c == 16'hFFFF) ? c : c + 16'd1;
	endfunction

	function automatic void push_verdict(input rfts_pkg::decision_t d, input logic [1:0] p,
			input logic [3:0] idx, input logic [15:0] cnt);
		verdict_t v;
		v.decision = d;
		v.port = p;
		v.entry_index = idx;
		v.entry_count = cnt;
		v.mode = link;
		pending_verdicts.insert(pending_verdicts.size(), v);
	endfunction

	function automatic void learn_rule(input logic [rfts_pkg::ADDR_W-1:0] lo,
			input logic [rfts_pkg::ADDR_W-1:0] hi, input logic drop, input logic [1:0] p);
		link = rfts_pkg::MODE_CONN;
		if (tbl_used >= NUM_ENTRIES) begin
			push_verdict(rfts_pkg::DEC_FULL, rfts_pkg::PORT_NONE, 4'd0, 16'd0);
		end else begin
			tbl_lo[tbl_used] = lo;
			tbl_hi[tbl_used] = hi;
			tbl_drop[tbl_used] = drop;
			tbl_port[tbl_used] = p;
			tbl_hits[tbl_used] = 16'd1;
			push_verdict(drop ? rfts_pkg::DEC_DROP : rfts_pkg::DEC_RELAY, p,
				tbl_used[3:0], 16'd1);
			tbl_used++;
		end
	endfunction

	// works out the verdict of one accepted beat and updates the shadow table
	function automatic void flow_lookup(input logic [2:0] act, input logic [2:0] tgt,
			input logic [rfts_pkg::ADDR_W-1:0] dst, input logic [rfts_pkg::ADDR_W-1:0] rlo,
			input logic [rfts_pkg::ADDR_W-1:0] rhi);
		bit hit;
		hit = 0;
		case (act)
			rfts_pkg::ACT_TRAFFIC: begin
				if (link != rfts_pkg::MODE_CONN) begin
					push_verdict(rfts_pkg::DEC_HOLD, rfts_pkg::PORT_NONE, 4'd0, 16'd0);
				end else if (tgt != my_switch) begin
					push_verdict(rfts_pkg::DEC_NONE, rfts_pkg::PORT_NONE, 4'd0, 16'd0);
				end else if (local_lo <= dst && dst <= local_hi) begin
					local_hits = bump(local_hits);
					push_verdict(rfts_pkg::DEC_ADMIT, rfts_pkg::PORT_LOCAL, 4'd0, local_hits);
				end else begin
					for (int i = 1; i < tbl_used && !hit; i++) begin
						if (tbl_lo[i] <= dst && dst <= tbl_hi[i]) begin
							hit = 1;
							tbl_hits[i] = bump(tbl_hits[i]);
							if (tbl_drop[i])
								push_verdict(rfts_pkg::DEC_DROP, rfts_pkg::PORT_NONE,
									i[3:0], tbl_hits[i]);
							else
								push_verdict(rfts_pkg::DEC_RELAY, tbl_port[i],
									i[3:0], tbl_hits[i]);
						end
					end
					if (!hit) begin
						link = rfts_pkg::MODE_WAIT;
						push_verdict(rfts_pkg::DEC_QUERY, rfts_pkg::PORT_NONE, 4'd0, 16'd0);
					end
				end
			end
			rfts_pkg::ACT_ADD_FWD: learn_rule(rlo, rhi, 1'b0,
				(tgt == my_switch) ? rfts_pkg::PORT_RIGHT : rfts_pkg::PORT_LEFT);
			rfts_pkg::ACT_ADD_DROP: learn_rule(dst, dst, 1'b1, rfts_pkg::PORT_NONE);
			rfts_pkg::ACT_RELAY: begin
				local_hits = bump(local_hits);
				push_verdict(rfts_pkg::DEC_ADMIT, rfts_pkg::PORT_LOCAL, 4'd0, local_hits);
			end
			rfts_pkg::ACT_ACK: begin
				link = rfts_pkg::MODE_CONN;
				push_verdict(rfts_pkg::DEC_NONE, rfts_pkg::PORT_NONE, 4'd0, 16'd0);
			end
			default: push_verdict(rfts_pkg::DEC_NONE, rfts_pkg::PORT_NONE, 4'd0, 16'd0);
		endcase
	endfunction

	// offer one beat, wait for it to be taken, then predict it
	task automatic send_item(input logic [2:0] act, input logic [2:0] tgt,
			input logic [rfts_pkg::ADDR_W-1:0] dst, input logic [rfts_pkg::ADDR_W-1:0] rlo,
			input logic [rfts_pkg::ADDR_W-1:0] rhi);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_gap_pct && gap < 20)
			gap++;
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.action <= act;
		item.target_switch <= tgt;
		item.dest_ip <= dst;
		item.range_low <= rlo;
		item.range_high <= rhi;
		do @(posedge clk); while (!item.ready);
		flow_lookup(act, tgt, dst, rlo, rhi);
	endtask

	// let every verdict arrive and the pipeline settle
	task automatic drain();
		item.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rfts_pkg::CFG_IDX_W-1:0] idx,
			input logic [rfts_pkg::ADDR_W-1:0] val);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			rfts_pkg::CFG_SWITCH_ID: my_switch = val[2:0];
			rfts_pkg::CFG_OWN_LOW:   local_lo = val;
			rfts_pkg::CFG_OWN_HIGH:  local_hi = val;
			default: ;
		endcase
	endtask

	// receiver: random idling, long hold-off, and the verdict check
	always @(posedge clk) begin
		if (stall_left > 0) begin
			result.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			result.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
		if (arst_n && result.valid && result.ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				verdict_t v;
				v = pending_verdicts.pop_front();
				if (result.decision != v.decision) begin
					$error("decision: expected %0d got %0d", v.decision, result.decision);
					errors++;
				end
				if (result.port != v.port) begin
					$error("port: expected %0d got %0d", v.port, result.port);
					errors++;
				end
				if (result.entry_index != v.entry_index) begin
					$error("entry_index: expected %0d got %0d", v.entry_index,
						result.entry_index);
					errors++;
				end
				if (result.entry_count != v.entry_count) begin
					$error("entry_count: expected %0d got %0d", v.entry_count,
						result.entry_count);
					errors++;
				end
				if (result.mode != v.mode) begin
					$error("mode: expected %0d got %0d", v.mode, result.mode);
					errors++;
				end
			end
		end
	end

	// every decision but a full table, every mode change and special case once
	task automatic test_directed();
		send_item(rfts_pkg::ACT_TRAFFIC, 3'd1, 10'd5, 10'd0, 10'd0);
		send_item(rfts_pkg::ACT_ACK, 3'd0, 10'd0, 10'd0, 10'd0);
		send_item(rfts_pkg::ACT_TRAFFIC, 3'd2, 10'd5, 10'd0, 10'd0);
		send_item(rfts_pkg::ACT_TRAFFIC, 3'd1, 10'd0, 10'd0, 10'd0);
		send_item(rfts_pkg::ACT_TRAFFIC, 3'd1, 10'd1000, 10'd0, 10'd0);
		send_item(rfts_pkg::ACT_RELAY, 3'd7, 10'd1023, 10'd1023, 10'd1023);
		send_item(3'd5, 3'd1, 10'd1, 10'd2, 10'd3);
		send_item(3'd6, 3'd1, 10'd1, 10'd2, 10'd3);
		send_item(3'd7, 3'd7, 10'd1023, 10'd1023, 10'd1023);
		write_reg(rfts_pkg::CFG_OWN_LOW, 10'd100);
		write_reg(rfts_pkg::CFG_OWN_HIGH, 10'd200);
		// address above the nominal maximum, no rule yet
		send_item(rfts_pkg::ACT_TRAFFIC, 3'd1, 10'd1023, 10'd0, 10'd0);
		send_item(rfts_pkg::ACT_TRAFFIC, 3'd1, 10'd150, 10'd0, 10'd0);
		send_item(rfts_pkg::ACT_ADD_FWD, 3'd1, 10'd0, 10'd300, 10'd400);
		send_item(rfts_pkg::ACT_ADD_FWD, 3'd3, 10'd0, 10'd0, 10'd50);
		send_item(rfts_pkg::ACT_ADD_DROP, 3'd0, 10'd1023, 10'd0, 10'd0);
		// empty range is stored but never hit
		send_item(rfts_pkg::ACT_ADD_FWD, 3'd1, 10'd0, 10'd600, 10'd500);
		send_item(rfts_pkg::ACT_TRAFFIC, 3'd1, 10'd1023, 10'd0, 10'd0);
		send_item(rfts_pkg::ACT_TRAFFIC, 3'd1, 10'd550, 10'd0, 10'd0);
		send_item(rfts_pkg::ACT_ACK, 3'd0, 10'd0, 10'd0, 10'd0);
		send_item(rfts_pkg::ACT_TRAFFIC, 3'd1, 10'd350, 10'd0, 10'd0);
		send_item(rfts_pkg::ACT_TRAFFIC, 3'd1, 10'd25, 10'd0, 10'd0);
		send_item(rfts_pkg::ACT_TRAFFIC, 3'd1, 10'd200, 10'd0, 10'd0);
	endtask

	// both counters climb on repeated hits
	task automatic test_counters();
		send_item(rfts_pkg::ACT_ADD_FWD, 3'd1, 10'd0, 10'd700, 10'd800);
		for (int i = 0; i < 16; i++)
			send_item(rfts_pkg::ACT_TRAFFIC, 3'd1, 10'd750, 10'd0, 10'd0);
		for (int i = 0; i < 16; i++)
			send_item(rfts_pkg::ACT_RELAY, 3'd0, 10'd0, 10'd0, 10'd0);
	endtask

	// mostly well-formed traffic aimed at known ranges, the rest noise
	task automatic test_random(input int count);
		int r, k;
		logic [rfts_pkg::ADDR_W-1:0] dst;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			dst = 10'($urandom_range(1023));
			if (link == rfts_pkg::MODE_WAIT && r < 85) begin
				if (r < 55)
					send_item(rfts_pkg::ACT_ACK, 3'($urandom), dst,
						10'($urandom), 10'($urandom));
				else if (r < 72)
					send_item(rfts_pkg::ACT_ADD_FWD, 3'($urandom), dst,
						10'($urandom), 10'($urandom));
				else
					send_item(rfts_pkg::ACT_ADD_DROP, 3'($urandom), dst,
						10'($urandom), 10'($urandom));
			end else if (r < 75) begin
				if ($urandom_range(1) && tbl_used > 1) begin
					k = $urandom_range(tbl_used - 1, 1);
					if (tbl_lo[k] <= tbl_hi[k])
						dst = 10'($urandom_range(tbl_hi[k], tbl_lo[k]));
				end else if ($urandom_range(3) == 0) begin
					dst = 10'($urandom_range(local_hi, local_lo));
				end
				send_item(rfts_pkg::ACT_TRAFFIC,
					($urandom_range(9) < 8) ? my_switch : 3'($urandom),
					dst, 10'($urandom), 10'($urandom));
			end else if (r < 80) begin
				send_item(rfts_pkg::ACT_RELAY, 3'($urandom), dst,
					10'($urandom), 10'($urandom));
			end else if (r < 83) begin
				send_item(rfts_pkg::ACT_ADD_FWD, 3'($urandom), dst,
					10'($urandom), 10'($urandom));
			end else if (r < 85) begin
				send_item(rfts_pkg::ACT_ADD_DROP, 3'($urandom), dst,
					10'($urandom), 10'($urandom));
			end else if (r < 90) begin
				send_item(rfts_pkg::ACT_ACK, 3'($urandom), dst,
					10'($urandom), 10'($urandom));
			end else begin
				send_item(3'($urandom), 3'($urandom), dst, 10'($urandom), 10'($urandom));
			end
		end
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		stall_left = 300;
		test_random(40);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item.valid = 1'b0;
		item.action = '0;
		item.target_switch = '0;
		item.dest_ip = '0;
		item.range_low = '0;
		item.range_high = '0;
		result.ready = 1'b0;
		errors = 0;
		stall_left = 0;
		tx_gap_pct = 0;
		rx_idle_pct = 0;
		my_switch = 3'd1;
		local_lo = 10'd0;
		local_hi = 10'd1000;
		local_hits = '0;
		tbl_used = 1;
		link = rfts_pkg::MODE_DISC;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_gap_pct = 12;
		rx_idle_pct = 50;
		test_directed();
		tx_gap_pct = 0;
		rx_idle_pct = 0;
		test_counters();

		tx_gap_pct = 12;
		rx_idle_pct = 50;
		write_reg(rfts_pkg::CFG_SWITCH_ID, 10'd7);
		write_reg(rfts_pkg::CFG_OWN_LOW, 10'd0);
		write_reg(rfts_pkg::CFG_OWN_HIGH, 10'd0);
		test_random(600);

		tx_gap_pct = 50;
		rx_idle_pct = 12;
		write_reg(rfts_pkg::CFG_SWITCH_ID, 10'd4);
		write_reg(rfts_pkg::CFG_OWN_LOW, 10'd1000);
		write_reg(rfts_pkg::CFG_OWN_HIGH, 10'd1000);
		test_random(600);

		tx_gap_pct = 0;
		rx_idle_pct = 0;
		write_reg(rfts_pkg::CFG_SWITCH_ID, 10'd1);
		write_reg(rfts_pkg::CFG_OWN_LOW, 10'd900);
		write_reg(rfts_pkg::CFG_OWN_HIGH, 10'd50);
		test_backpressure();
		write_reg(rfts_pkg::CFG_OWN_LOW, 10'd400);
		write_reg(rfts_pkg::CFG_OWN_HIGH, 10'd600);
		test_random(560);

		drain();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
